[sv/crtc_pkg.sv]
// crtc_pkg: shared constants, widths, register indexes and interface structs
// for the circular roi threshold centroid core
// no dependencies; every other file refers to it by scoped names
package crtc_pkg;

    // coordinate and fixed point sizing
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 4;

    // fixed field widths
    localparam int PIXEL_W    = 8;
    localparam int LEVEL_W    = 8;
    localparam int RADIUS_W   = 8;
    localparam int CENTER_W   = 12;
    localparam int CFG_SIZE_W = 13;
    localparam int SUM_W      = 32;
    localparam int COUNT_W    = 18;
    localparam int CENT_W     = 16;

    // derived widths
    localparam int SIZE_W   = (COORD_BITS + 1 > CFG_SIZE_W) ? COORD_BITS + 1 : CFG_SIZE_W;
    localparam int POS_W    = (COORD_BITS > CENTER_W) ? COORD_BITS : CENTER_W;
    localparam int DELTA_W  = POS_W + 1;
    localparam int SQ_W     = 2 * POS_W;
    localparam int DIST_W   = SQ_W + 1;
    localparam int RSQ_W    = 2 * RADIUS_W;
    localparam int DVD_W    = SUM_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SIZE_W-1:0]  SIZE_MAX  = SIZE_W'(1) << COORD_BITS;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CIRCLE_CENTER_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CIRCLE_CENTER_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CIRCLE_RADIUS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = 3'd5;

    localparam logic [CFG_SIZE_W-1:0] RST_IMAGE_WIDTH     = 13'd640;
    localparam logic [CFG_SIZE_W-1:0] RST_IMAGE_HEIGHT    = 13'd480;
    localparam logic [CENTER_W-1:0]   RST_CIRCLE_CENTER_X = 12'd320;
    localparam logic [CENTER_W-1:0]   RST_CIRCLE_CENTER_Y = 12'd240;
    localparam logic [RADIUS_W-1:0]   RST_CIRCLE_RADIUS   = 8'd20;
    localparam logic [LEVEL_W-1:0]    RST_LEVEL_THRESHOLD = 8'h80;

    // stream packing
    localparam int M_TDATA_W = ((2 * CENT_W + COUNT_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIVIDE,
        ST_EMIT
    } crtc_state_t;

    typedef struct packed {
        logic [CFG_SIZE_W-1:0] image_width;
        logic [CFG_SIZE_W-1:0] image_height;
        logic [CENTER_W-1:0]   center_x;
        logic [CENTER_W-1:0]   center_y;
        logic [RADIUS_W-1:0]   radius;
        logic [LEVEL_W-1:0]    threshold;
    } crtc_cfg_t;

    typedef struct packed {
        logic take;
        logic square;
        logic accum;
        logic div_start;
        logic emit;
    } crtc_cmd_t;

    typedef struct packed {
        logic frame_end;
        logic div_done;
        logic out_free;
    } crtc_stat_t;

endpackage

[sv/crtc_div.sv]
// crtc_div: restoring divider, one quotient bit per cycle, keeps the low
// CENT_W bits of the quotient
// depends on crtc_pkg
module crtc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [crtc_pkg::DVD_W-1:0]   dividend,
    input  logic [crtc_pkg::COUNT_W-1:0] divisor,
    output logic                        done,
    output logic [crtc_pkg::CENT_W-1:0]  quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [crtc_pkg::DIV_CNT_W-1:0]    step_reg, step_next;
    logic [crtc_pkg::DVD_W-1:0]        dvd_reg, dvd_next;
    logic [crtc_pkg::COUNT_W-1:0]      dsr_reg, dsr_next;
    logic [crtc_pkg::COUNT_W-1:0]      rem_reg, rem_next;
    logic [crtc_pkg::CENT_W-1:0]       quo_reg, quo_next;
    logic [crtc_pkg::COUNT_W:0]        trial;
    logic [crtc_pkg::COUNT_W:0]        diff;
    logic                              fits;
    logic                              last_step;

    always_comb begin
        trial     = {rem_reg, dvd_reg[crtc_pkg::DVD_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        fits      = trial >= {1'b0, dsr_reg};
        last_step = step_reg == crtc_pkg::DIV_CNT_W'(crtc_pkg::DVD_W - 1);

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;

        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end else if (busy_reg) begin
            step_next = step_reg + 1'b1;
            dvd_next  = dvd_reg << 1;
            rem_next  = fits ? diff[crtc_pkg::COUNT_W-1:0] : trial[crtc_pkg::COUNT_W-1:0];
            quo_next  = {quo_reg[crtc_pkg::CENT_W-2:0], fits};
            if (last_step) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[sv/crtc_ctrl.sv]
// crtc_ctrl: sequencing state machine for pixel intake, circle test,
// accumulation, centroid division and result hand-off
// depends on crtc_pkg
module crtc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  crtc_pkg::crtc_stat_t stat,
    output crtc_pkg::crtc_cmd_t  cmd
);

    crtc_pkg::crtc_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= crtc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            crtc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    state_next = crtc_pkg::ST_SQUARE;
                end
            end
            crtc_pkg::ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = crtc_pkg::ST_ACCUM;
            end
            crtc_pkg::ST_ACCUM: begin
                cmd.accum = 1'b1;
                if (stat.frame_end) begin
                    cmd.div_start = 1'b1;
                    state_next    = crtc_pkg::ST_DIVIDE;
                end else begin
                    state_next = crtc_pkg::ST_IDLE;
                end
            end
            crtc_pkg::ST_DIVIDE: begin
                if (stat.div_done) begin
                    state_next = crtc_pkg::ST_EMIT;
                end
            end
            crtc_pkg::ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = crtc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = crtc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[sv/crtc_dp.sv]
// crtc_dp: raster position, circle and level test, running sums and count,
// two centroid dividers and the result register
// depends on crtc_pkg and crtc_div
module crtc_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  crtc_pkg::crtc_cfg_t           cfg,
    input  crtc_pkg::crtc_cmd_t           cmd,
    output crtc_pkg::crtc_stat_t          stat,
    input  logic [crtc_pkg::PIXEL_W-1:0]  pixel_value,
    input  logic                          frame_start,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [crtc_pkg::CENT_W-1:0]   centroid_x,
    output logic [crtc_pkg::CENT_W-1:0]   centroid_y,
    output logic [crtc_pkg::COUNT_W-1:0]  pixel_count,
    output logic                          region_empty
);

    // frame state
    logic [crtc_pkg::COORD_BITS-1:0] col_reg, col_next;
    logic [crtc_pkg::COORD_BITS-1:0] row_reg, row_next;
    logic [crtc_pkg::SUM_W-1:0]      sum_x_reg, sum_x_next;
    logic [crtc_pkg::SUM_W-1:0]      sum_y_reg, sum_y_next;
    logic [crtc_pkg::COUNT_W-1:0]    cnt_reg, cnt_next;

    // per pixel pipeline
    logic [crtc_pkg::PIXEL_W-1:0]    pix_reg;
    logic                            bright_reg;
    logic [crtc_pkg::SQ_W-1:0]       dx2_reg, dy2_reg;
    logic [crtc_pkg::RSQ_W-1:0]      r2_reg;

    // result hold while dividing
    logic [crtc_pkg::COUNT_W-1:0]    fin_cnt_reg;

    // output register
    logic                            m_valid_reg, m_valid_next;
    logic [crtc_pkg::CENT_W-1:0]     m_cx_reg, m_cy_reg;
    logic [crtc_pkg::COUNT_W-1:0]    m_cnt_reg;
    logic                            m_empty_reg;

    logic [crtc_pkg::DELTA_W-1:0]    dx, dy;
    logic [crtc_pkg::POS_W-1:0]      dx_mag, dy_mag;
    logic [crtc_pkg::DIST_W-1:0]     dist2;
    logic                            hit;
    logic [crtc_pkg::SIZE_W-1:0]     w_eff, h_eff;
    logic [crtc_pkg::SIZE_W-1:0]     col_inc, row_inc;
    logic                            row_end, frame_end;
    logic [crtc_pkg::SUM_W-1:0]      sum_x_upd, sum_y_upd;
    logic [crtc_pkg::COUNT_W-1:0]    cnt_upd;
    logic                            done_x, done_y;
    logic [crtc_pkg::CENT_W-1:0]     quo_x, quo_y;
    logic                            fin_empty;

    // signed offsets from the circle center, folded to magnitudes
    always_comb begin
        dx     = crtc_pkg::DELTA_W'(col_reg) - crtc_pkg::DELTA_W'(cfg.center_x);
        dy     = crtc_pkg::DELTA_W'(row_reg) - crtc_pkg::DELTA_W'(cfg.center_y);
        dx_mag = dx[crtc_pkg::DELTA_W-1] ? crtc_pkg::POS_W'(-dx) : dx[crtc_pkg::POS_W-1:0];
        dy_mag = dy[crtc_pkg::DELTA_W-1] ? crtc_pkg::POS_W'(-dy) : dy[crtc_pkg::POS_W-1:0];
    end

    // clamped frame size and raster end detection
    always_comb begin
        w_eff = crtc_pkg::SIZE_W'(cfg.image_width);
        h_eff = crtc_pkg::SIZE_W'(cfg.image_height);
        if (w_eff == '0) begin
            w_eff = crtc_pkg::SIZE_W'(1);
        end else if (w_eff > crtc_pkg::SIZE_MAX) begin
            w_eff = crtc_pkg::SIZE_MAX;
        end
        if (h_eff == '0) begin
            h_eff = crtc_pkg::SIZE_W'(1);
        end else if (h_eff > crtc_pkg::SIZE_MAX) begin
            h_eff = crtc_pkg::SIZE_MAX;
        end
        col_inc   = crtc_pkg::SIZE_W'(col_reg) + 1'b1;
        row_inc   = crtc_pkg::SIZE_W'(row_reg) + 1'b1;
        row_end   = col_inc >= w_eff;
        frame_end = row_end && (row_inc >= h_eff);
    end

    // accumulation of a counted pixel
    always_comb begin
        dist2     = crtc_pkg::DIST_W'(dx2_reg) + crtc_pkg::DIST_W'(dy2_reg);
        hit       = bright_reg && (dist2 <= crtc_pkg::DIST_W'(r2_reg));
        sum_x_upd = sum_x_reg;
        sum_y_upd = sum_y_reg;
        cnt_upd   = cnt_reg;
        if (hit) begin
            sum_x_upd = sum_x_reg + crtc_pkg::SUM_W'(col_reg);
            sum_y_upd = sum_y_reg + crtc_pkg::SUM_W'(row_reg);
            if (cnt_reg != crtc_pkg::COUNT_MAX) begin
                cnt_upd = cnt_reg + 1'b1;
            end
        end
    end

    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        cnt_next   = cnt_reg;
        if (cmd.take && frame_start) begin
            col_next   = '0;
            row_next   = '0;
            sum_x_next = '0;
            sum_y_next = '0;
            cnt_next   = '0;
        end else if (cmd.accum) begin
            if (frame_end) begin
                col_next   = '0;
                row_next   = '0;
                sum_x_next = '0;
                sum_y_next = '0;
                cnt_next   = '0;
            end else begin
                sum_x_next = sum_x_upd;
                sum_y_next = sum_y_upd;
                cnt_next   = cnt_upd;
                if (row_end) begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            cnt_reg   <= cnt_next;
        end
    end

    // pixel intake and squaring stage, and count capture at division start
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            pix_reg <= pixel_value;
        end
        if (cmd.square) begin
            bright_reg <= pix_reg > cfg.threshold;
            dx2_reg    <= crtc_pkg::SQ_W'(dx_mag) * crtc_pkg::SQ_W'(dx_mag);
            dy2_reg    <= crtc_pkg::SQ_W'(dy_mag) * crtc_pkg::SQ_W'(dy_mag);
            r2_reg     <= crtc_pkg::RSQ_W'(cfg.radius) * crtc_pkg::RSQ_W'(cfg.radius);
        end
        if (cmd.div_start) begin
            fin_cnt_reg <= cnt_upd;
        end
    end

    crtc_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (crtc_pkg::DVD_W'(sum_x_upd) << crtc_pkg::FRAC_BITS),
        .divisor  (cnt_upd),
        .done     (done_x),
        .quotient (quo_x)
    );

    crtc_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (crtc_pkg::DVD_W'(sum_y_upd) << crtc_pkg::FRAC_BITS),
        .divisor  (cnt_upd),
        .done     (done_y),
        .quotient (quo_y)
    );

    // result register
    assign fin_empty = fin_cnt_reg == '0;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (cmd.emit) begin
            m_cx_reg    <= fin_empty ? '0 : quo_x;
            m_cy_reg    <= fin_empty ? '0 : quo_y;
            m_cnt_reg   <= fin_cnt_reg;
            m_empty_reg <= fin_empty;
        end
    end

    assign stat.frame_end = frame_end;
    assign stat.div_done  = done_x;
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign centroid_x   = m_cx_reg;
    assign centroid_y   = m_cy_reg;
    assign pixel_count  = m_cnt_reg;
    assign region_empty = m_empty_reg;

    // both dividers run in lockstep
    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        done_x == done_y)
        else $error("centroid dividers out of step");

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    // an empty region carries zero centroids
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_empty_reg) |-> (m_cx_reg == '0 && m_cy_reg == '0))
        else $error("empty region with nonzero centroid");

    // no pixel enters while a frame end is being divided
    a_no_take_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> !cmd.take)
        else $error("pixel taken during division");

    // a frame end always clears the raster position
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accum && frame_end) |=> (col_reg == '0 && row_reg == '0 && cnt_reg == '0))
        else $error("frame end did not clear state");

endmodule

[sv/circular_roi_threshold_centroid_core.sv]
// circular_roi_threshold_centroid_core: top level, configuration registers,
// stream packing, controller and datapath instances
// depends on crtc_pkg, crtc_ctrl, crtc_dp (and crtc_div through it)
//
// usage
//   s_* carries grey pixels in raster order, one word per pixel; s_tuser marks
//   the first pixel of a frame, which restarts position, sums and count.
//   a pixel counts when it lies in the circle (squared distance to the center
//   at most radius squared) and is strictly above the level threshold.
//   after the last pixel of a frame (set by image_width and image_height)
//   one word leaves on m_*: both centroids in unsigned fixed point with
//   FRAC_BITS fraction bits (truncated), the count and an empty flag.
//   cfg_* writes one register per handshake; cfg_ready is always high and
//   writes are expected only while the core is idle.
// sequence
//   each pixel passes intake, squaring multiply, then sum and compare before
//   the next one is taken. at a frame end the two centroid dividers (one
//   quotient bit per cycle) work through all DVD_W (36) dividend bits and
//   raise done; the result word then goes into the output register once it
//   is free. intake pauses while the dividers run.
// reset and stall
//   aresetn (synchronous, active low) restores the register defaults and
//   clears position, sums and count; no result is pending after reset.
//   a waiting result sits in the output register while pixels keep flowing;
//   only a second frame end stalls intake until that result is taken.
module circular_roi_threshold_centroid_core (
    input  logic                              aclk,
    input  logic                              aresetn,

    // pixel stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] pixel_value
    input  logic [0:0]                        s_tuser,   // [0] frame_start

    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [crtc_pkg::M_TDATA_W-1:0]    m_tdata,   // [15:0] centroid_x,
                                                         // [31:16] centroid_y,
                                                         // [49:32] pixel_count
    output logic [0:0]                        m_tuser,   // [0] region_empty

    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [crtc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [crtc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    crtc_pkg::crtc_cfg_t  cfg_reg, cfg_next;
    crtc_pkg::crtc_cmd_t  cmd;
    crtc_pkg::crtc_stat_t stat;

    logic [crtc_pkg::CENT_W-1:0]  centroid_x, centroid_y;
    logic [crtc_pkg::COUNT_W-1:0] pixel_count;
    logic                         region_empty;

    assign cfg_ready = 1'b1;

    // register file, unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                crtc_pkg::REG_IMAGE_WIDTH: begin
                    cfg_next.image_width = cfg_data;
                end
                crtc_pkg::REG_IMAGE_HEIGHT: begin
                    cfg_next.image_height = cfg_data;
                end
                crtc_pkg::REG_CIRCLE_CENTER_X: begin
                    cfg_next.center_x = cfg_data[crtc_pkg::CENTER_W-1:0];
                end
                crtc_pkg::REG_CIRCLE_CENTER_Y: begin
                    cfg_next.center_y = cfg_data[crtc_pkg::CENTER_W-1:0];
                end
                crtc_pkg::REG_CIRCLE_RADIUS: begin
                    cfg_next.radius = cfg_data[crtc_pkg::RADIUS_W-1:0];
                end
                crtc_pkg::REG_LEVEL_THRESHOLD: begin
                    cfg_next.threshold = cfg_data[crtc_pkg::LEVEL_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width  <= crtc_pkg::RST_IMAGE_WIDTH;
            cfg_reg.image_height <= crtc_pkg::RST_IMAGE_HEIGHT;
            cfg_reg.center_x     <= crtc_pkg::RST_CIRCLE_CENTER_X;
            cfg_reg.center_y     <= crtc_pkg::RST_CIRCLE_CENTER_Y;
            cfg_reg.radius       <= crtc_pkg::RST_CIRCLE_RADIUS;
            cfg_reg.threshold    <= crtc_pkg::RST_LEVEL_THRESHOLD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // sequencing
    crtc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // position, sums, dividers and output register
    crtc_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .stat         (stat),
        .pixel_value  (s_tdata),
        .frame_start  (s_tuser[0]),
        .m_ready      (m_tready),
        .m_valid      (m_tvalid),
        .centroid_x   (centroid_x),
        .centroid_y   (centroid_y),
        .pixel_count  (pixel_count),
        .region_empty (region_empty)
    );

    // result word packing, first field lowest
    assign m_tdata = crtc_pkg::M_TDATA_W'({pixel_count, centroid_y, centroid_x});
    assign m_tuser = region_empty;

endmodule
